[rtl/dpfa_pkg.sv]
package dpfa_pkg;

  localparam int EXP_BITS_DEF  = 11;
  localparam int FRAC_BITS_DEF = 52;
  localparam int WORD_BITS     = 64;

  typedef struct packed {
    logic [WORD_BITS-1:0] operand_a;
    logic [WORD_BITS-1:0] operand_b;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] sum_bits;
    logic                 overflowed;
    logic                 inexact;
    logic                 invalid;
  } out_beat_t;

endpackage

[rtl/dpfa_norm.sv]
// Leading-zero count of a working significand, limited by the exponent so
// that the shift never takes the exponent below one (gradual underflow).
module dpfa_norm #(
  parameter int MW = 57,
  parameter int EW = 13
) (
  input  logic [MW-1:0] m,
  input  logic [EW-1:0] e,
  output logic [EW-1:0] shamt
);
  logic [EW-1:0] lz;
  logic          found;
  always_comb begin
    lz    = EW'(MW);
    found = 1'b0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (m[i] && !found) begin
        lz    = EW'(MW - 1 - i);
        found = 1'b1;
      end
    end
    shamt = (lz > (e - EW'(1))) ? (e - EW'(1)) : lz;
  end
endmodule

[rtl/double_precision_float_adder_unit.sv]
// IEEE 754 adder, binary64 at default parameters, round to nearest even.
// Path: an input beat is registered in stages 1, 2 and 3, then in the output register.
// Throughput: one beat per cycle; a four-stage pipeline that advances on
// every cycle in which the output register is free or being taken.
// Reset: rst_n synchronous, active low, clears only the stage valid bits.
module double_precision_float_adder_unit #(
  parameter int EXP_BITS  = dpfa_pkg::EXP_BITS_DEF,
  parameter int FRAC_BITS = dpfa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dpfa_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dpfa_pkg::out_beat_t out_data
);
  localparam int W   = 1 + EXP_BITS + FRAC_BITS;
  localparam int MW  = FRAC_BITS + 5;      // carry, hidden, fraction, g r s
  localparam int EW  = EXP_BITS + 2;
  localparam int TOP = FRAC_BITS + 3;
  localparam logic [EXP_BITS-1:0] EMAX = '1;
  localparam logic [W-1:0] QNAN = {1'b0, EMAX, 1'b1, {(FRAC_BITS-1){1'b0}}};

  // Whole pipe moves together; a stall at the output holds every stage.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- stage 1: order by magnitude, decode ----------------
  logic [W-1:0] a, b, big, sml;
  assign a   = in_data.operand_a[W-1:0];
  assign b   = in_data.operand_b[W-1:0];
  assign big = (a[W-2:0] < b[W-2:0]) ? b : a;
  assign sml = (a[W-2:0] < b[W-2:0]) ? a : b;

  logic                v1_r;
  logic                sa1_r, sb1_r, spec1_r, inv1_r;
  logic [W-1:0]        spec_val1_r;
  logic [MW-1:0]       ma1_r, mb1_r;
  logic [EW-1:0]       e1_r, d1_r;

  logic [EXP_BITS-1:0] ea, eb;
  logic [FRAC_BITS-1:0] fa, fb;
  logic nan_a, nan_b, sig;
  assign ea = big[W-2:FRAC_BITS];
  assign eb = sml[W-2:FRAC_BITS];
  assign fa = big[FRAC_BITS-1:0];
  assign fb = sml[FRAC_BITS-1:0];
  assign nan_a = (ea == EMAX) && (fa != '0);
  assign nan_b = (eb == EMAX) && (fb != '0);
  assign sig = (nan_a && !fa[FRAC_BITS-1]) || (nan_b && !fb[FRAC_BITS-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa1_r <= big[W-1];
      sb1_r <= sml[W-1];
      ma1_r <= {1'b0, (ea != '0), fa, 3'b000};
      mb1_r <= {1'b0, (eb != '0), fb, 3'b000};
      e1_r  <= (ea != '0) ? EW'(ea) : EW'(1);
      d1_r  <= ((ea != '0) ? EW'(ea) : EW'(1)) - ((eb != '0) ? EW'(eb) : EW'(1));
      if (nan_a || nan_b) begin
        spec1_r <= 1'b1; spec_val1_r <= QNAN; inv1_r <= sig;
      end else if (ea == EMAX) begin
        spec1_r <= 1'b1;
        inv1_r  <= (eb == EMAX) && (big[W-1] != sml[W-1]);
        spec_val1_r <= ((eb == EMAX) && (big[W-1] != sml[W-1])) ? QNAN
                     : {big[W-1], EMAX, {FRAC_BITS{1'b0}}};
      end else begin
        spec1_r <= 1'b0; spec_val1_r <= '0; inv1_r <= 1'b0;
      end
    end
  end

  // ---------------- stage 2: align with sticky, add/subtract ----------------
  logic [MW-1:0] mb_al, msum;
  always_comb begin
    if (d1_r > EW'(FRAC_BITS + 4)) begin
      mb_al = {{(MW-1){1'b0}}, (mb1_r != '0)};
    end else begin
      mb_al = (mb1_r >> d1_r) |
              MW'((mb1_r & ((MW'(1) << d1_r) - MW'(1))) != '0);
    end
    msum = (sa1_r == sb1_r) ? ma1_r + mb_al : ma1_r - mb_al;
  end

  logic          v2_r, same2_r, s2_r, spec2_r, inv2_r;
  logic [W-1:0]  spec_val2_r;
  logic [MW-1:0] m2_r;
  logic [EW-1:0] e2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r <= msum; e2_r <= e1_r; s2_r <= sa1_r; same2_r <= (sa1_r == sb1_r);
      spec2_r <= spec1_r; spec_val2_r <= spec_val1_r; inv2_r <= inv1_r;
    end
  end

  // ---------------- stage 3: normalize ----------------
  logic [EW-1:0] shamt;
  dpfa_norm #(.MW(MW - 1), .EW(EW)) u_norm (
    .m(m2_r[MW-2:0]), .e(e2_r), .shamt(shamt)
  );

  logic [MW-1:0] mn;
  logic [EW-1:0] en;
  always_comb begin
    if (m2_r[TOP+1]) begin
      mn = (m2_r >> 1) | MW'(m2_r[0]);
      en = e2_r + EW'(1);
    end else begin
      mn = m2_r << shamt;
      en = e2_r - shamt;
    end
  end

  logic          v3_r, s3_r, spec3_r, inv3_r;
  logic [W-1:0]  spec_val3_r;
  logic [MW-1:0] m3_r;
  logic [EW-1:0] e3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_r <= mn; e3_r <= en; s3_r <= s2_r; inv3_r <= inv2_r;
      spec3_r <= spec2_r || (m2_r == '0);
      // Exact zero: positive unless both signs agree.
      spec_val3_r <= spec2_r ? spec_val2_r
                   : (same2_r ? {s2_r, {(W-1){1'b0}}} : '0);
    end
  end

  // ---------------- stage 4: round, repack ----------------
  logic [2:0]           grs;
  logic [FRAC_BITS+1:0] mant;
  logic [EW-1:0]        er;
  logic                 up;
  logic [W-1:0]         res;
  logic                 ovf, inx;
  always_comb begin
    grs  = m3_r[2:0];
    up   = (grs > 3'd4) || (grs == 3'd4 && m3_r[3]);
    mant = m3_r[FRAC_BITS+4:3] + (FRAC_BITS+2)'(up);
    er   = e3_r;
    if (mant[FRAC_BITS+1]) begin
      mant = mant >> 1;
      er   = er + EW'(1);
    end
    inx = (grs != 3'b000);
    ovf = 1'b0;
    if (spec3_r) begin
      res = spec_val3_r; inx = 1'b0;
    end else if (er >= EW'(EMAX)) begin
      res = {s3_r, EMAX, {FRAC_BITS{1'b0}}}; ovf = 1'b1; inx = 1'b1;
    end else begin
      res = {s3_r, (mant[FRAC_BITS] ? er[EXP_BITS-1:0] : {EXP_BITS{1'b0}}),
             mant[FRAC_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.sum_bits   <= dpfa_pkg::WORD_BITS'(res);
      out_data.overflowed <= ovf;
      out_data.inexact    <= inx;
      out_data.invalid    <= inv3_r;
    end
  end
endmodule

[rtl/dpfa_checker.sv]
module dpfa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input dpfa_pkg::out_beat_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");
  a_stall_map: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");
  a_ovf_inx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflowed |-> out_data.inexact && !out_data.invalid)
    else $error("overflow without inexact");
  a_inv_nan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |-> out_data.sum_bits[62:52] == 11'h7FF
      && !out_data.overflowed)
    else $error("invalid without NaN result");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted beat missing after four cycles");
endmodule

bind double_precision_float_adder_unit dpfa_checker u_dpfa_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

[dv/double_precision_float_adder_unit_tb.sv]
`timescale 1ns / 1ps

module double_precision_float_adder_unit_tb;

  localparam int EB = dpfa_pkg::EXP_BITS_DEF;
  localparam int FB = dpfa_pkg::FRAC_BITS_DEF;
  localparam int SIGN_POS = EB + FB;
  localparam logic [63:0] EXP_ALL = (64'd1 << EB) - 64'd1;
  localparam logic [63:0] FRAC_MASK = (64'd1 << FB) - 64'd1;
  localparam logic [63:0] HIDDEN = 64'd1 << FB;
  localparam logic [63:0] QUIET = 64'd1 << (FB - 1);
  localparam logic [63:0] WORD_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (63 - EB - FB);
  localparam logic [63:0] QNAN = (EXP_ALL << FB) | QUIET;
  localparam int TOP_POS = FB + 3;
  localparam int N_RANDOM = 700;
  localparam int CYCLE_LIMIT = 200000;

  // Predict one sum beat: order by magnitude, align with sticky, add or subtract,
  // normalize, round to nearest even, repack with gradual underflow.
  function automatic dpfa_pkg::out_beat_t fp_add_predict(logic [63:0] op_a,
                                                         logic [63:0] op_b);
    dpfa_pkg::out_beat_t r;
    logic [63:0] a, b, t, mag, sa, sb, ea, eb, fa, fb, ma, mb, m, mant, e, ebe, d, grs, ex;
    logic nan_a, nan_b, up;
    r = '0;
    a = op_a & WORD_MASK;
    b = op_b & WORD_MASK;
    mag = WORD_MASK >> 1;
    if ((a & mag) < (b & mag)) begin
      t = a; a = b; b = t;
    end
    sa = (a >> SIGN_POS) & 64'd1;
    sb = (b >> SIGN_POS) & 64'd1;
    ea = (a >> FB) & EXP_ALL;
    eb = (b >> FB) & EXP_ALL;
    fa = a & FRAC_MASK;
    fb = b & FRAC_MASK;
    nan_a = (ea == EXP_ALL) && (fa != 0);
    nan_b = (eb == EXP_ALL) && (fb != 0);
    if (nan_a || nan_b) begin
      r.sum_bits = QNAN;
      r.invalid = (nan_a && (fa & QUIET) == 0) || (nan_b && (fb & QUIET) == 0);
      return r;
    end
    if (ea == EXP_ALL) begin
      if (eb == EXP_ALL && sa != sb) begin
        r.sum_bits = QNAN;
        r.invalid = 1'b1;
      end else begin
        r.sum_bits = (sa << SIGN_POS) | (EXP_ALL << FB);
      end
      return r;
    end
    ma = (fa | (ea != 0 ? HIDDEN : 64'd0)) << 3;
    mb = (fb | (eb != 0 ? HIDDEN : 64'd0)) << 3;
    e = (ea != 0) ? ea : 64'd1;
    ebe = (eb != 0) ? eb : 64'd1;
    d = e - ebe;
    // Shift the smaller significand right, folding lost bits into sticky.
    if (d > FB + 4) mb = (mb != 0) ? 64'd1 : 64'd0;
    else if (d != 0) mb = (mb >> d) | ((mb & ((64'd1 << d) - 64'd1)) != 0);
    m = (sa == sb) ? ma + mb : ma - mb;
    if (m == 0) begin
      r.sum_bits = (sa == sb) ? (sa << SIGN_POS) : 64'd0;
      return r;
    end
    if ((m >> (TOP_POS + 1)) != 0) begin
      m = (m >> 1) | (m & 64'd1);
      e++;
    end else begin
      while (m[TOP_POS] == 1'b0 && e > 1) begin
        m = m << 1;
        e--;
      end
    end
    grs = m & 64'd7;
    mant = m >> 3;
    up = (grs > 4) || (grs == 4 && mant[0]);
    if (up) mant++;
    if ((mant >> (FB + 1)) != 0) begin
      mant = mant >> 1;
      e++;
    end
    r.inexact = (grs != 0);
    if (e >= EXP_ALL) begin
      r.sum_bits = (sa << SIGN_POS) | (EXP_ALL << FB);
      r.overflowed = 1'b1;
      r.inexact = 1'b1;
      return r;
    end
    ex = ((mant >> FB) != 0) ? e : 64'd0;
    r.sum_bits = (sa << SIGN_POS) | (ex << FB) | (mant & FRAC_MASK);
    return r;
  endfunction

  int mismatch_count = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  class sum_scoreboard;
    dpfa_pkg::out_beat_t pending_sums[$];

    function void note_operands(dpfa_pkg::in_beat_t beat);
      pending_sums.push_back(fp_add_predict(beat.operand_a, beat.operand_b));
    endfunction

    task check_sum(dpfa_pkg::out_beat_t got);
      dpfa_pkg::out_beat_t want;
      if (pending_sums.size() == 0) begin
        report_mismatch("unexpected beat", got.sum_bits, 64'd0);
        return;
      end
      want = pending_sums.pop_front();
      if (got.sum_bits !== want.sum_bits) report_mismatch("sum_bits", got.sum_bits, want.sum_bits);
      if (got.overflowed !== want.overflowed)
        report_mismatch("overflowed", got.overflowed, want.overflowed);
      if (got.inexact !== want.inexact) report_mismatch("inexact", got.inexact, want.inexact);
      if (got.invalid !== want.invalid) report_mismatch("invalid", got.invalid, want.invalid);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dpfa_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dpfa_pkg::out_beat_t out_data;

  sum_scoreboard sb = new();
  bit hold_off_on = 1'b0;
  int cycle_count = 0;

  double_precision_float_adder_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Build a binary64 pattern from its fields.
  function automatic logic [63:0] pack_fp(logic s, logic [10:0] ex, logic [51:0] fr);
    return {s, ex, fr};
  endfunction

  // Draw a random operand, biased toward interesting exponent ranges.
  function automatic logic [63:0] rand_operand(logic [63:0] near);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v[62:52] = 11'h7FF;                                  // inf / NaN
      1: v[62:52] = 11'h000;                                  // zero / subnormal
      2: v[62:52] = 11'(11'h7FE - $urandom_range(0, 2));      // near overflow
      3, 4: v[62:52] = 11'(near[62:52] + $urandom_range(0, 3) - 2); // close, cancellation
      5: v[51:0] = $urandom_range(0, 1) ? '0 : v[51:0];
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) v[51:0] = {52{v[0]}};
    return v;
  endfunction

  // Offer one beat, after a random gap unless no_gap is set, and hold it until it is taken.
  task automatic send_operands(logic [63:0] a, logic [63:0] b, bit no_gap);
    int gap;
    dpfa_pkg::in_beat_t beat;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.operand_a = a;
    beat.operand_b = b;
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (in_stall);
    sb.note_operands(beat);
  endtask

  // Receiver: draw a stall length per beat; one long hold-off fills the pipe.
  initial begin
    int wait_cycles;
    @(posedge rst_n);
    forever begin
      if (hold_off_on) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off_on = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_sum(out_data);
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [63:0] dir_a[$];
    logic [63:0] dir_b[$];
    logic [63:0] a, b;
    int drain;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zeros of both signs, infinities, NaNs, extremes, subnormals,
    // exact cancellation, overflow.
    dir_a = '{pack_fp(0, 0, 0), pack_fp(1, 0, 0), pack_fp(1, 0, 0),
              pack_fp(0, 11'h7FF, 0), pack_fp(0, 11'h7FF, 0), pack_fp(1, 11'h7FF, 0),
              pack_fp(0, 11'h7FF, 52'h1), pack_fp(1, 11'h7FF, QUIET[51:0]),
              pack_fp(0, 11'h7FE, '1), pack_fp(1, 11'h7FE, '1),
              pack_fp(0, 0, 52'h1), pack_fp(0, 0, '1), pack_fp(0, 11'h3FF, 0),
              pack_fp(0, 11'h3FF, 52'h1), pack_fp(0, 11'h3FF, 0), pack_fp(1, 11'h001, 0),
              pack_fp(0, 11'h434, 0), 64'hFFFF_FFFF_FFFF_FFFF, pack_fp(0, 11'h7FE, 0)};
    dir_b = '{pack_fp(0, 0, 0), pack_fp(1, 0, 0), pack_fp(0, 0, 0),
              pack_fp(1, 11'h7FF, 0), pack_fp(0, 11'h7FF, 0), pack_fp(0, 11'h3FF, 0),
              pack_fp(0, 11'h3FF, 0), pack_fp(0, 11'h7FF, 0),
              pack_fp(0, 11'h7FE, '1), pack_fp(1, 11'h7CA, 0),
              pack_fp(0, 0, 52'h1), pack_fp(0, 0, 52'h1), pack_fp(1, 11'h3FF, 0),
              pack_fp(1, 11'h3FF, 0), pack_fp(0, 11'h3C9, 0), pack_fp(0, 0, '1),
              pack_fp(0, 11'h3FF, 52'h8_0000_0000_0000), 64'h0, pack_fp(0, 11'h7CA, 0)};
    foreach (dir_a[i]) send_operands(dir_a[i], dir_b[i], 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_off_on = 1'b1;
      a = rand_operand({$urandom, $urandom});
      b = rand_operand(a);
      if ($urandom_range(0, 9) == 0) b = {~a[63], a[62:0]};
      // Run back-to-back through the hold-off so the pipe fills and stalls input.
      send_operands(a, b, (i >= 300 && i < 360) || (i % 97 < 12));
    end
    in_valid <= 1'b0;

    while (sb.pending_sums.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 20) begin
      @(posedge clk);
      drain++;
    end
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
